// ----- rtl/ufct_pkg.sv -----
// ----------------------------------------------------------------------------
// ufct_pkg
// Shared constants and types for the UDP flow counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package ufct_pkg;

    localparam int TABLE_SLOTS = 8;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SLOT_OUT_W  = 3;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SERVER_IP   = 1'b0;
    localparam logic REG_SERVER_PORT = 1'b1;

    localparam logic [31:0] SERVER_IP_RESET   = 32'h0A0A_0A14;
    localparam logic [15:0] SERVER_PORT_RESET = 16'd1414;

    localparam logic [1:0] ACT_FILTERED = 2'd0;
    localparam logic [1:0] ACT_FULL     = 2'd1;
    localparam logic [1:0] ACT_FREED    = 2'd2;
    localparam logic [1:0] ACT_REPLY    = 2'd3;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    // Ethernet header plus UDP header, in bytes
    localparam logic [6:0]  FIXED_HDR_LEN  = 7'd22;

    typedef struct packed {
        logic load_in;  // capture the input word
        logic exec;     // look up, update the table, load the result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ufct_ctrl.sv -----
// ----------------------------------------------------------------------------
// ufct_ctrl
// Sequencer: takes a word, runs the table update, holds the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ufct_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ufct_pkg::ctrl_cmd_t    cmd
);
    import ufct_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic exec;

    // result slot is free when empty or being drained this cycle
    assign exec = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.load_in = in_valid && in_ready;
    assign cmd.exec    = exec;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ufct_datapath.sv -----
// ----------------------------------------------------------------------------
// ufct_datapath
// Config registers, input word register, client table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufct_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ufct_pkg::ctrl_cmd_t             cmd,
    input  wire logic [10:0]                     frame_len,
    input  wire logic [3:0]                      ip_header_words,
    input  wire logic [15:0]                     eth_type,
    input  wire logic [7:0]                      ip_protocol,
    input  wire logic [31:0]                     dst_ip,
    input  wire logic [15:0]                     dst_port,
    input  wire logic [31:0]                     src_ip,
    input  wire logic [15:0]                     src_port,
    input  wire logic [15:0]                     udp_len,
    input  wire logic                            is_exit,
    output logic [1:0]                           action,
    output logic [ufct_pkg::SLOT_OUT_W-1:0]      slot,
    output logic [31:0]                          count,
    input  wire logic                            cfg_we,
    input  wire logic [ufct_pkg::ADDR_W-1:0]     cfg_addr,
    input  wire logic [ufct_pkg::DATA_W-1:0]     cfg_wdata,
    output logic [ufct_pkg::DATA_W-1:0]          cfg_rdata
);
    import ufct_pkg::*;

    logic [31:0] server_ip_reg;
    logic [15:0] server_port_reg;

    logic [10:0] frame_len_reg;
    logic [3:0]  ihl_reg;
    logic [15:0] eth_type_reg;
    logic [7:0]  proto_reg;
    logic [31:0] dst_ip_reg;
    logic [15:0] dst_port_reg;
    logic [31:0] src_ip_reg;
    logic [15:0] src_port_reg;
    logic [15:0] udp_len_reg;
    logic        is_exit_reg;

    logic        slot_valid_reg [TABLE_SLOTS];
    logic [31:0] slot_ip_reg    [TABLE_SLOTS];
    logic [15:0] slot_port_reg  [TABLE_SLOTS];
    logic [31:0] slot_count_reg [TABLE_SLOTS];

    logic [1:0]            action_reg;
    logic [1:0]            action_next;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [SLOT_OUT_W-1:0] slot_next;
    logic [31:0]           count_reg;
    logic [31:0]           count_next;

    logic [6:0]        min_len;
    logic              pass;
    logic [TABLE_SLOTS-1:0] hit_vec;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    logic              have_slot;
    logic [SLOT_W-1:0] sel_idx;
    logic [31:0]       base_count;
    logic [31:0]       new_count;
    logic              tbl_we;

    // ---------------- config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg   <= SERVER_IP_RESET;
            server_port_reg <= SERVER_PORT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr[2])
                REG_SERVER_IP:   server_ip_reg   <= cfg_wdata;
                REG_SERVER_PORT: server_port_reg <= cfg_wdata[15:0];
                default:         server_ip_reg   <= server_ip_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_addr[2])
            REG_SERVER_IP:   cfg_rdata = server_ip_reg;
            REG_SERVER_PORT: cfg_rdata = {{(DATA_W-16){1'b0}}, server_port_reg};
            default:         cfg_rdata = '0;
        endcase
    end

    // ---------------- input word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            frame_len_reg  <= frame_len;
            ihl_reg        <= ip_header_words;
            eth_type_reg   <= eth_type;
            proto_reg      <= ip_protocol;
            dst_ip_reg     <= dst_ip;
            dst_port_reg   <= dst_port;
            src_ip_reg     <= src_ip;
            src_port_reg   <= src_port;
            udp_len_reg    <= udp_len;
            is_exit_reg    <= is_exit;
        end
    end

    // ---------------- filter
    assign min_len = FIXED_HDR_LEN + {1'b0, ihl_reg, 2'b00};

    // udp_len below 8 is let through on purpose; only exactly 8 drops
    assign pass = (frame_len_reg >= {4'b0, min_len}) &&
                  (eth_type_reg == ETHERTYPE_IPV4) &&
                  (proto_reg == PROTO_UDP) &&
                  (dst_ip_reg == server_ip_reg) &&
                  (dst_port_reg == server_port_reg) &&
                  (udp_len_reg != UDP_HDR_LEN);

    // ---------------- lookup
    always_comb
    begin
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            hit_vec[k] = slot_valid_reg[k] && (slot_ip_reg[k] == src_ip_reg) &&
                         (slot_port_reg[k] == src_port_reg);
        end
    end

    assign hit = |hit_vec;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int k = TABLE_SLOTS - 1; k >= 0; k--)
        begin
            if (hit_vec[k])
                hit_idx = SLOT_W'(k);
            if (!slot_valid_reg[k])
            begin
                free_idx = SLOT_W'(k);
                free_any = 1'b1;
            end
        end
    end

    assign have_slot  = hit || free_any;
    assign sel_idx    = hit ? hit_idx : free_idx;
    // a fresh slot starts from zero
    assign base_count = hit ? slot_count_reg[hit_idx] : 32'd0;
    assign new_count  = (base_count == 32'hFFFF_FFFF) ? base_count : base_count + 32'd1;
    assign tbl_we     = cmd.exec && pass && have_slot;

    always_comb
    begin
        action_next = ACT_FILTERED;
        slot_next   = '0;
        count_next  = '0;
        if (pass)
        begin
            priority if (!have_slot)
            begin
                action_next = ACT_FULL;
            end
            else if (is_exit_reg)
            begin
                action_next = ACT_FREED;
                slot_next   = SLOT_OUT_W'(sel_idx);
            end
            else
            begin
                action_next = ACT_REPLY;
                slot_next   = SLOT_OUT_W'(sel_idx);
                count_next  = new_count;
            end
        end
    end

    // ---------------- table
    // exit from an unknown client takes and frees the slot at once: net clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_SLOTS; k++)
            begin
                slot_valid_reg[k] <= 1'b0;
                slot_ip_reg[k]    <= '0;
                slot_port_reg[k]  <= '0;
                slot_count_reg[k] <= '0;
            end
        end
        else if (tbl_we)
        begin
            if (is_exit_reg)
            begin
                slot_valid_reg[sel_idx] <= 1'b0;
                slot_ip_reg[sel_idx]    <= '0;
                slot_port_reg[sel_idx]  <= '0;
                slot_count_reg[sel_idx] <= '0;
            end
            else
            begin
                slot_valid_reg[sel_idx] <= 1'b1;
                slot_ip_reg[sel_idx]    <= src_ip_reg;
                slot_port_reg[sel_idx]  <= src_port_reg;
                slot_count_reg[sel_idx] <= new_count;
            end
        end
    end

    // ---------------- result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            action_reg <= action_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
        end
    end

    assign action = action_reg;
    assign slot   = slot_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

// ----- rtl/udp_flow_counter_table_unit.sv -----
// ----------------------------------------------------------------------------
// udp_flow_counter_table_unit
// UDP server front end: filters headers and counts packets per client slot.
// ----------------------------------------------------------------------------
// Path: input register, then parallel slot compare and table update into the
// result register; the update waits while the previous result is undrained.
// No new word is taken until the current word has loaded the result register.
// A new word is taken while the previous result waits on out_ready.
// Reset: all slots free and zeroed, server_ip 10.10.10.20, server_port 1414.
`default_nettype none

module udp_flow_counter_table_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [10:0]                     frame_len,
    input  wire logic [3:0]                      ip_header_words,
    input  wire logic [15:0]                     eth_type,
    input  wire logic [7:0]                      ip_protocol,
    input  wire logic [31:0]                     dst_ip,
    input  wire logic [15:0]                     dst_port,
    input  wire logic [31:0]                     src_ip,
    input  wire logic [15:0]                     src_port,
    input  wire logic [15:0]                     udp_len,
    input  wire logic                            is_exit,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           action,
    output logic [ufct_pkg::SLOT_OUT_W-1:0]      slot,
    output logic [31:0]                          count,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ufct_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [ufct_pkg::DATA_W-1:0]     pwdata,
    output logic [ufct_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import ufct_pkg::*;

    ctrl_cmd_t cmd;
    logic      cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    ufct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ufct_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .frame_len       (frame_len),
        .ip_header_words (ip_header_words),
        .eth_type        (eth_type),
        .ip_protocol     (ip_protocol),
        .dst_ip          (dst_ip),
        .dst_port        (dst_port),
        .src_ip          (src_ip),
        .src_port        (src_port),
        .udp_len         (udp_len),
        .is_exit         (is_exit),
        .action          (action),
        .slot            (slot),
        .count           (count),
        .cfg_we          (cfg_we),
        .cfg_addr        (paddr),
        .cfg_wdata       (pwdata),
        .cfg_rdata       (prdata)
    );

    // one word in flight: no back-to-back accept
    a_no_b2b_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted in consecutive cycles");

    // the result register only loads while the input side is busy
    a_exec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !in_ready)
        else $error("result loaded while input idle");

    a_drop_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_FILTERED || action == ACT_FULL)) |-> (slot == '0))
        else $error("dropped word carries a slot");

    a_count_only_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action != ACT_REPLY) |-> (count == 32'd0))
        else $error("count nonzero on a non-reply word");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for udp_flow_counter_table_unit. Headers go in through a
// valid/ready driver fed from a queue and results come back through a
// monitor. A local model of the filter and the slot table predicts every
// result word. Server address and port are changed over APB between phases.
// ----------------------------------------------------------------------------

module tb_top;

    import ufct_pkg::*;

    localparam int MAX_FRAME = 1518;
    localparam int CLIENTS   = 10;

    typedef struct packed {
        logic [10:0] frame_len;
        logic [3:0]  ip_header_words;
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] udp_len;
        logic        is_exit;
    } hdr_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [SLOT_OUT_W-1:0] slot;
        logic [31:0]           count;
    } flow_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    hdr_t                  cur_hdr = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            action;
    logic [SLOT_OUT_W-1:0] slot;
    logic [31:0]           count;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // model copy of the registers and the client table
    logic [31:0] cfg_ip = SERVER_IP_RESET;
    logic [15:0] cfg_port = SERVER_PORT_RESET;
    logic        tbl_live [TABLE_SLOTS];
    logic [31:0] tbl_ip [TABLE_SLOTS];
    logic [15:0] tbl_port [TABLE_SLOTS];
    logic [31:0] tbl_count [TABLE_SLOTS];

    hdr_t         hdr_queue[$];
    flow_result_t flow_expect[$];
    logic [31:0]  client_ip [CLIENTS];
    logic [15:0]  client_port [CLIENTS];

    logic word_taken = 1'b0;
    logic sink_hold = 1'b0;
    int   idle_pct = 21;
    int   hdrs_taken = 0;
    int   cfg_writes = 0;
    int   err_cnt = 0;
    int   act_seen [4] = '{0, 0, 0, 0};

    udp_flow_counter_table_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .frame_len       (cur_hdr.frame_len),
        .ip_header_words (cur_hdr.ip_header_words),
        .eth_type        (cur_hdr.eth_type),
        .ip_protocol     (cur_hdr.ip_protocol),
        .dst_ip          (cur_hdr.dst_ip),
        .dst_port        (cur_hdr.dst_port),
        .src_ip          (cur_hdr.src_ip),
        .src_port        (cur_hdr.src_port),
        .udp_len         (cur_hdr.udp_len),
        .is_exit         (cur_hdr.is_exit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .action          (action),
        .slot            (slot),
        .count           (count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Filter, then match or allocate a slot; updates the table copy.
    function automatic flow_result_t advance_flow_table(input hdr_t h);
        flow_result_t r;
        int           hit;
        r.action = ACT_FILTERED;
        r.slot   = '0;
        r.count  = '0;
        if (int'(h.frame_len) < int'(FIXED_HDR_LEN) + 4 * int'(h.ip_header_words) ||
            h.eth_type != ETHERTYPE_IPV4 || h.ip_protocol != PROTO_UDP ||
            h.dst_ip != cfg_ip || h.dst_port != cfg_port || h.udp_len == UDP_HDR_LEN)
            return r;
        hit = -1;
        for (int k = 0; k < TABLE_SLOTS; k++)
            if (hit < 0 && tbl_live[k] && tbl_ip[k] == h.src_ip && tbl_port[k] == h.src_port)
                hit = k;
        for (int k = 0; k < TABLE_SLOTS; k++)
            if (hit < 0 && !tbl_live[k])
            begin
                hit          = k;
                tbl_live[k]  = 1'b1;
                tbl_ip[k]    = h.src_ip;
                tbl_port[k]  = h.src_port;
                tbl_count[k] = '0;
            end
        if (hit < 0)
            r.action = ACT_FULL;
        else if (h.is_exit)
        begin
            tbl_live[hit]  = 1'b0;
            tbl_ip[hit]    = '0;
            tbl_port[hit]  = '0;
            tbl_count[hit] = '0;
            r.action       = ACT_FREED;
            r.slot         = hit[SLOT_OUT_W-1:0];
        end
        else
        begin
            if (tbl_count[hit] != '1)
                tbl_count[hit] = tbl_count[hit] + 1;
            r.action = ACT_REPLY;
            r.slot   = hit[SLOT_OUT_W-1:0];
            r.count  = tbl_count[hit];
        end
        return r;
    endfunction

    function automatic hdr_t fixed_pkt(input logic [31:0] sip, input logic [15:0] sport,
                                       input int flen, input int ihl, input int ulen,
                                       input logic leave);
        hdr_t h;
        h.frame_len       = 11'(flen);
        h.ip_header_words = 4'(ihl);
        h.eth_type        = ETHERTYPE_IPV4;
        h.ip_protocol     = PROTO_UDP;
        h.dst_ip          = cfg_ip;
        h.dst_port        = cfg_port;
        h.src_ip          = sip;
        h.src_port        = sport;
        h.udp_len         = 16'(ulen);
        h.is_exit         = leave;
        return h;
    endfunction

    // header that passes the current server's filter, with random sizes
    function automatic hdr_t to_server(input logic [31:0] sip, input logic [15:0] sport,
                                       input logic leave);
        hdr_t h;
        int   ihl;
        int   ulen;
        int   u;
        ihl = $urandom_range(15);
        u   = $urandom_range(3);
        if (u == 0)
            ulen = $urandom_range(7);
        else if (u == 1)
            ulen = $urandom_range(65535, 9);
        else
            ulen = $urandom_range(1480, 9);
        h = fixed_pkt(sip, sport,
                      $urandom_range(MAX_FRAME, int'(FIXED_HDR_LEN) + 4 * ihl),
                      ihl, ulen, leave);
        return h;
    endfunction

    function automatic void load_directed();
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [31:0] ip_e;
        hdr_t        h;
        ip_a = 32'h0000_0000;
        ip_b = 32'hFFFF_FFFF;
        ip_e = 32'h0B0B_0B0B;
        // frame length right at the minimum for several IHLs, one below it for IHL 5 and 15, and zero
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 42, 5, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 41, 5, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 82, 15, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 81, 15, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 22, 0, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 0, 0, 100, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_b, 16'hFFFF, MAX_FRAME, 15, 65535, 1'b0));
        h = fixed_pkt(ip_b, 16'hFFFF, 200, 5, 100, 1'b0);
        h.eth_type = 16'h86DD;
        hdr_queue.push_back(h);
        h = fixed_pkt(ip_b, 16'hFFFF, 200, 5, 100, 1'b0);
        h.ip_protocol = 8'd6;
        hdr_queue.push_back(h);
        h = fixed_pkt(ip_b, 16'hFFFF, 200, 5, 100, 1'b0);
        h.dst_ip = cfg_ip ^ 32'h1;
        hdr_queue.push_back(h);
        h = fixed_pkt(ip_b, 16'hFFFF, 200, 5, 100, 1'b0);
        h.dst_port = cfg_port + 16'd1;
        hdr_queue.push_back(h);
        // udp_len of exactly 8 drops; below 8 passes
        hdr_queue.push_back(fixed_pkt(ip_b, 16'hFFFF, 200, 5, 8, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_b, 16'hFFFF, 200, 5, 0, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_b, 16'hFFFF, 200, 5, 7, 1'b0));
        // exit from a client never seen: allocate and free at once
        hdr_queue.push_back(fixed_pkt(32'hC0A8_0001, 16'd5000, 200, 5, 12, 1'b1));
        for (int i = 0; i < TABLE_SLOTS - 2; i++)
            hdr_queue.push_back(fixed_pkt(32'hC0A8_0100 + i, 16'(6000 + i), 200, 5, 64, 1'b0));
        // table full, for a normal word and for an exit word
        hdr_queue.push_back(fixed_pkt(ip_e, 16'd7777, 200, 5, 64, 1'b0));
        hdr_queue.push_back(fixed_pkt(ip_e, 16'd7777, 200, 5, 64, 1'b1));
        hdr_queue.push_back(fixed_pkt(ip_a, 16'h0000, 200, 5, 12, 1'b1));
        hdr_queue.push_back(fixed_pkt(ip_e, 16'd7777, 200, 5, 64, 1'b0));
    endfunction

    function automatic void queue_random(input int n);
        hdr_t h;
        int   pick;
        int   c;
        int   min_len;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            c    = $urandom_range(CLIENTS - 1);
            h    = to_server(client_ip[c], client_port[c], $urandom_range(99) < 12);
            if (pick >= 70 && pick < 85)
            begin
                min_len = int'(FIXED_HDR_LEN) + 4 * int'(h.ip_header_words);
                case ($urandom_range(5))
                    0: h.frame_len = 11'($urandom_range(min_len - 1));
                    1: h.eth_type = h.eth_type ^ (16'h1 << $urandom_range(15));
                    2: h.ip_protocol = h.ip_protocol ^ (8'h1 << $urandom_range(7));
                    3: h.dst_ip = h.dst_ip ^ (32'h1 << $urandom_range(31));
                    4: h.dst_port = h.dst_port ^ (16'h1 << $urandom_range(15));
                    default: h.udp_len = UDP_HDR_LEN;
                endcase
            end
            else if (pick >= 85)
            begin
                h.frame_len       = 11'($urandom_range(MAX_FRAME));
                h.ip_header_words = 4'($urandom_range(15));
                h.eth_type        = $urandom_range(1) ? ETHERTYPE_IPV4 : 16'($urandom);
                h.ip_protocol     = $urandom_range(1) ? PROTO_UDP : 8'($urandom);
                h.dst_ip          = $urandom;
                h.dst_port        = 16'($urandom);
                h.src_ip          = $urandom;
                h.src_port        = 16'($urandom);
                h.udp_len         = 16'($urandom);
                h.is_exit         = 1'($urandom_range(1));
            end
            hdr_queue.push_back(h);
        end
    endfunction

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_SERVER_IP)
            cfg_ip = value;
        else
            cfg_port = value[15:0];
        cfg_writes++;
    endtask

    // checked at the rising edge, where the driver's signals are settled
    task automatic wait_drain();
        do
            @(posedge clk);
        while (hdr_queue.size() != 0 || in_valid || flow_expect.size() != 0);
    endtask

    // header driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (hdr_queue.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_hdr  <= hdr_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !sink_hold && ($urandom_range(99) >= idle_pct);
    end

    // long receiver hold-off so the unit backs up and drops in_ready
    initial
    begin
        wait (hdrs_taken >= 60);
        @(posedge clk);
        sink_hold = 1'b1;
        repeat (60) @(posedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        flow_result_t want;
        if (!rst_n)
            word_taken <= 1'b0;
        else
        begin
            word_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (flow_expect.size() == 0)
                begin
                    $error("unexpected result word: action=%0d slot=%0d count=%0d",
                           action, slot, count);
                    err_cnt++;
                end
                else
                begin
                    want = flow_expect.pop_front();
                    act_seen[want.action]++;
                    if (action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, action);
                        err_cnt++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, slot);
                        err_cnt++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                flow_expect.push_back(advance_flow_table(cur_hdr));
                hdrs_taken++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $error("timeout with %0d results outstanding", flow_expect.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            tbl_live[k]  = 1'b0;
            tbl_ip[k]    = '0;
            tbl_port[k]  = '0;
            tbl_count[k] = '0;
        end
        for (int c = 0; c < CLIENTS; c++)
        begin
            client_ip[c]   = $urandom;
            client_port[c] = 16'($urandom);
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_directed();
        wait_drain();

        // all-zero, all-ones (no idling), random, then back to reset values
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = (p == 1) ? 0 : 21;
            case (p)
                0:
                begin
                    write_reg(REG_SERVER_IP, 32'h0000_0000);
                    write_reg(REG_SERVER_PORT, 32'h0000_0000);
                end
                1:
                begin
                    write_reg(REG_SERVER_IP, 32'hFFFF_FFFF);
                    write_reg(REG_SERVER_PORT, 32'h0000_FFFF);
                end
                2:
                begin
                    write_reg(REG_SERVER_IP, $urandom);
                    write_reg(REG_SERVER_PORT, $urandom_range(65535));
                end
                default:
                begin
                    write_reg(REG_SERVER_IP, SERVER_IP_RESET);
                    write_reg(REG_SERVER_PORT, {16'h0, SERVER_PORT_RESET});
                end
            endcase
            // bring a few new clients in each phase
            for (int c = 0; c < 3; c++)
            begin
                client_ip[$urandom_range(CLIENTS - 1)]   = $urandom;
                client_port[$urandom_range(CLIENTS - 1)] = 16'($urandom);
            end
            @(posedge clk);
            queue_random(110);
            wait_drain();
        end
        repeat (10) @(negedge clk);

        $display("Ran %0d headers under %0d register writes (zero, all-ones, random, reset).",
                 hdrs_taken, cfg_writes);
        $display("Results: %0d replies, %0d freed, %0d table full, %0d filtered.",
                 act_seen[ACT_REPLY], act_seen[ACT_FREED], act_seen[ACT_FULL],
                 act_seen[ACT_FILTERED]);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ufct_pkg.sv
rtl/ufct_ctrl.sv
rtl/ufct_datapath.sv
rtl/udp_flow_counter_table_unit.sv
dv/tb_top.sv
